// ===== src/kiss_frame_deframer_defines.svh =====
// ----------------------------------------------------------------------------
// KISS frame deframer assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef KISS_FRAME_DEFRAMER_DEFINES_SVH
`define KISS_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge out of reset.
`define KFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never occurs.
`define KFD_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define KFD_ASSERT(label, prop, msg)
`define KFD_ASSERT_NEVER(label, expr, msg)

`endif

`endif

// ===== src/kfd_pkg.sv =====
// ----------------------------------------------------------------------------
// KISS frame deframer package
// Shared constants, codes and word types of the deframer.
// ----------------------------------------------------------------------------
package kfd_pkg;

    // Largest number of stored bytes (command byte included) in one frame
    localparam int MAX_FRAME = 512;
    localparam int POS_W     = $clog2(MAX_FRAME + 1);

    localparam int KIND_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int TIME_W     = 32;
    localparam int TIMEOUT_W  = 16;
    localparam int FLEN_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POLL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;

    // KISS special bytes
    localparam logic [BYTE_W-1:0] FEND_CODE  = 8'hC0;
    localparam logic [BYTE_W-1:0] FESC_CODE  = 8'hDB;
    localparam logic [BYTE_W-1:0] TFEND_CODE = 8'hDC;
    localparam logic [BYTE_W-1:0] TFESC_CODE = 8'hDD;

    // Command byte of a port 0 data frame
    localparam logic [BYTE_W-1:0] CMD_DATA_PORT0 = 8'h00;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELIVER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT   = 2'd1;

    localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RESET = 16'd1000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] byte_value;
        logic [TIME_W-1:0] now_ms;
    } kfd_in_t;

    typedef struct packed {
        logic              consumed;
        logic              data_valid;
        logic [BYTE_W-1:0] data_byte;
        logic              frame_end;
        logic              frame_ok;
        logic [FLEN_W-1:0] frame_length;
        logic              aborted;
    } kfd_out_t;

endpackage

// ===== src/kiss_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// KISS frame deframer: res_valid rises once the result queue holds a result word.
// One word per cycle while the queue has room, set by kfd_core's single-pass step.
// rst_n clears frame state, config registers and queues; no clearing pass.
// ----------------------------------------------------------------------------
module kiss_frame_deframer
    import kfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input channel: received bytes, poll ticks, reset requests
    input  logic                  rx_valid,
    output logic                  rx_stall,
    input  kfd_in_t               rx_word,
    // Result channel: one result word per input word
    output logic                  res_valid,
    input  logic                  res_stall,
    output kfd_out_t              res_word,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Structure:
    //   rx_word -> input register -> kfd_core step logic -> kfd_out_fifo -> res_word
    // The input register captures one word per cycle unless it holds a blocked
    // word. The step fires when the input register holds a word and the result
    // queue has room; the core then updates its frame state and pushes exactly
    // one result word. The result queue is two deep and its room flag comes
    // from its count alone, so res_stall never reaches rx_stall through logic
    // and a queue holding one word still lets a word through every cycle.

    kfd_in_t  in_word_reg;
    logic     in_valid_reg, in_valid_next;
    logic     fifo_room;
    logic     advance;
    kfd_out_t step_result;

    // Advance the held word when the queue can take its result
    assign advance  = in_valid_reg && fifo_room;
    // Hold the source only while a word sits blocked in the input register
    assign rx_stall = in_valid_reg && !fifo_room;

    assign in_valid_next = (rx_valid && !rx_stall) ? 1'b1
                         : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Capture the payload on every accepted word
    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
        begin
            in_word_reg <= rx_word;
        end
    end

    kfd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_en   (advance),
        .item      (in_word_reg),
        .result    (step_result)
    );

    kfd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .push_word (step_result),
        .room      (fifo_room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

endmodule

// ===== src/kfd_core.sv =====
// ----------------------------------------------------------------------------
// KISS deframer core
// Frame state registers, configuration registers and the per-word step logic.
// ----------------------------------------------------------------------------
`include "kiss_frame_deframer_defines.svh"

module kfd_core
    import kfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  step_en,
    input  kfd_in_t               item,
    output kfd_out_t              result
);

    localparam int LEN_TMP_W = (POS_W > FLEN_W) ? POS_W : FLEN_W;

    logic                 deliver_enable_reg;
    logic [TIMEOUT_W-1:0] idle_timeout_reg;

    logic              in_frame_reg,       in_frame_next;
    logic              escape_pending_reg, escape_pending_next;
    logic              overrun_reg,        overrun_next;
    logic [POS_W-1:0]  byte_position_reg,  byte_position_next;
    logic [BYTE_W-1:0] command_byte_reg,   command_byte_next;
    logic [TIME_W-1:0] last_byte_time_reg, last_byte_time_next;

    logic [TIME_W-1:0]    elapsed;
    logic                 timed_out;
    logic [BYTE_W-1:0]    byte_eff;
    logic                 store;
    logic [POS_W-1:0]     len_m1;
    logic [LEN_TMP_W-1:0] len_tmp;
    logic                 verdict_ok;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deliver_enable_reg <= 1'b0;
            idle_timeout_reg   <= IDLE_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DELIVER_ENABLE: deliver_enable_reg <= cfg_data[0];
                CFG_IDLE_TIMEOUT:   idle_timeout_reg   <= cfg_data[TIMEOUT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Shared terms of the step
    assign elapsed    = item.now_ms - last_byte_time_reg;
    assign timed_out  = elapsed >= TIME_W'(idle_timeout_reg);
    assign len_m1     = (byte_position_reg == '0) ? '0 : byte_position_reg - 1'b1;
    assign len_tmp    = LEN_TMP_W'(len_m1);
    assign verdict_ok = !overrun_reg
                        && (byte_position_reg >= POS_W'(2))
                        && (byte_position_reg <= POS_W'(MAX_FRAME))
                        && deliver_enable_reg
                        && (command_byte_reg == CMD_DATA_PORT0);

    always_comb
    begin
        in_frame_next       = in_frame_reg;
        escape_pending_next = escape_pending_reg;
        overrun_next        = overrun_reg;
        byte_position_next  = byte_position_reg;
        command_byte_next   = command_byte_reg;
        last_byte_time_next = last_byte_time_reg;
        result              = '0;
        byte_eff            = item.byte_value;
        store               = 1'b0;

        case (item.kind)
            KIND_BYTE:
            begin
                last_byte_time_next = item.now_ms;
                if (item.byte_value == FEND_CODE)
                begin
                    if (in_frame_reg)
                    begin
                        result.frame_end    = 1'b1;
                        result.frame_ok     = verdict_ok;
                        result.frame_length = len_tmp[FLEN_W-1:0];
                    end
                    // Close whatever was open and start a new frame
                    in_frame_next       = 1'b1;
                    escape_pending_next = 1'b0;
                    overrun_next        = 1'b0;
                    byte_position_next  = '0;
                    result.consumed     = 1'b1;
                end
                else if (in_frame_reg)
                begin
                    result.consumed = 1'b1;
                    store           = 1'b1;
                    if (escape_pending_reg)
                    begin
                        escape_pending_next = 1'b0;
                        if (item.byte_value == TFEND_CODE)
                        begin
                            byte_eff = FEND_CODE;
                        end
                        else if (item.byte_value == TFESC_CODE)
                        begin
                            byte_eff = FESC_CODE;
                        end
                    end
                    else if (item.byte_value == FESC_CODE)
                    begin
                        escape_pending_next = 1'b1;
                        store               = 1'b0;
                    end

                    if (store)
                    begin
                        if (byte_position_reg >= POS_W'(MAX_FRAME))
                        begin
                            overrun_next = 1'b1;
                        end
                        else
                        begin
                            if (byte_position_reg == '0)
                            begin
                                command_byte_next = byte_eff;
                            end
                            else
                            begin
                                result.data_valid = 1'b1;
                                result.data_byte  = byte_eff;
                            end
                            byte_position_next = byte_position_reg + 1'b1;
                        end
                    end
                end
            end

            KIND_POLL:
            begin
                if ((in_frame_reg || escape_pending_reg) && timed_out)
                begin
                    in_frame_next       = 1'b0;
                    escape_pending_next = 1'b0;
                    overrun_next        = 1'b0;
                    byte_position_next  = '0;
                    last_byte_time_next = item.now_ms;
                    result.aborted      = 1'b1;
                end
            end

            KIND_RESET:
            begin
                result.aborted      = in_frame_reg || escape_pending_reg;
                in_frame_next       = 1'b0;
                escape_pending_next = 1'b0;
                overrun_next        = 1'b0;
                byte_position_next  = '0;
            end

            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg       <= 1'b0;
            escape_pending_reg <= 1'b0;
            overrun_reg        <= 1'b0;
            byte_position_reg  <= '0;
            command_byte_reg   <= '0;
            last_byte_time_reg <= '0;
        end
        else if (step_en)
        begin
            in_frame_reg       <= in_frame_next;
            escape_pending_reg <= escape_pending_next;
            overrun_reg        <= overrun_next;
            byte_position_reg  <= byte_position_next;
            command_byte_reg   <= command_byte_next;
            last_byte_time_reg <= last_byte_time_next;
        end
    end

    `KFD_ASSERT(a_escape_needs_frame, escape_pending_reg |-> in_frame_reg, "escape pending outside a frame")
    `KFD_ASSERT(a_overrun_at_limit, overrun_reg |-> (byte_position_reg == POS_W'(MAX_FRAME)), "overrun below frame limit")
    `KFD_ASSERT_NEVER(a_position_range, byte_position_reg > POS_W'(MAX_FRAME), "byte position past frame limit")
    `KFD_ASSERT(a_reset_closes, (step_en && item.kind == KIND_RESET) |=> !in_frame_reg, "frame still open after reset request")
    `KFD_ASSERT_NEVER(a_ok_without_end, step_en && result.frame_ok && !result.frame_end, "frame verdict without frame end")

endmodule

// ===== src/kfd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// KISS deframer result buffer
// Two-entry result queue; room depends on the stored count only.
// ----------------------------------------------------------------------------
module kfd_out_fifo
    import kfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  kfd_out_t push_word,
    output logic     room,
    output logic     res_valid,
    input  logic     res_stall,
    output kfd_out_t res_word
);

    kfd_out_t   mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       pop;

    assign room      = (count_reg != 2'd2);
    assign res_valid = (count_reg != 2'd0);
    assign res_word  = mem_reg[rd_ptr_reg];
    assign pop       = res_valid && !res_stall;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    // Payload storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== test/kiss_frame_deframer_test.sv =====
// ----------------------------------------------------------------------------
// KISS frame deframer regression
// Drives received bytes, poll ticks and reset requests into the deframer. A
// local deframe model predicts every result word, and each word that comes
// out is compared field by field against it. The run covers a directed part,
// a full-size and an overrun frame, and random traffic under several settings.
// ----------------------------------------------------------------------------
module kiss_frame_deframer_test;
    import kfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Kind code that the block defines no action for
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // No-progress cycles tolerated before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 80;

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  rx_valid  = 1'b0;
    logic                  rx_stall;
    kfd_in_t               rx_word   = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    kfd_out_t              res_word;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    kiss_frame_deframer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_word   (rx_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Deframe model: configuration and frame state, as they stand after reset
    // ------------------------------------------------------------------------
    logic                 dlv_en   = 1'b0;
    logic [TIMEOUT_W-1:0] idle_ms  = IDLE_TIMEOUT_RESET;
    logic                 fr_open  = 1'b0;
    logic                 esc_pend = 1'b0;
    logic                 overrun  = 1'b0;
    logic [POS_W-1:0]     fill     = '0;
    logic [BYTE_W-1:0]    cmd      = '0;
    logic [TIME_W-1:0]    last_ms  = '0;

    // Result words still owed by the block, oldest first
    kfd_out_t due_words[$];

    int items_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int idle_count   = 0;

    // Stimulus side: suppress idling on both channels while set
    bit                quiet        = 1'b0;
    logic [TIME_W-1:0] ms_now       = '0;
    logic [TIME_W-1:0] last_byte_ms = '0;
    logic [TIME_W-1:0] gen_timeout  = IDLE_TIMEOUT_RESET;

    // Drop the open frame; command byte and byte time survive
    function automatic void drop_frame();
        fr_open  = 1'b0;
        esc_pend = 1'b0;
        overrun  = 1'b0;
        fill     = '0;
    endfunction

    // Advance the model by one accepted word and return the word it owes
    function automatic kfd_out_t deframe_step(kfd_in_t w);
        kfd_out_t          r;
        logic [BYTE_W-1:0] b;
        logic              keep;
        r = '0;
        b = w.byte_value;
        keep = 1'b1;
        case (w.kind)
            KIND_BYTE:
            begin
                last_ms = w.now_ms;
                if (b == FEND_CODE)
                begin
                    // Close whatever is open, then open a fresh frame
                    if (fr_open)
                    begin
                        r.frame_end    = 1'b1;
                        r.frame_ok     = !overrun && fill >= 2 && dlv_en
                                         && cmd == CMD_DATA_PORT0;
                        r.frame_length = (fill > 0) ? FLEN_W'(fill - 1) : '0;
                    end
                    drop_frame();
                    fr_open    = 1'b1;
                    r.consumed = 1'b1;
                end
                else if (fr_open)
                begin
                    r.consumed = 1'b1;
                    if (esc_pend)
                    begin
                        // Unknown escapes pass through literally
                        esc_pend = 1'b0;
                        if (b == TFEND_CODE)
                            b = FEND_CODE;
                        else if (b == TFESC_CODE)
                            b = FESC_CODE;
                    end
                    else if (b == FESC_CODE)
                    begin
                        esc_pend = 1'b1;
                        keep     = 1'b0;
                    end
                    if (keep)
                    begin
                        if (fill >= MAX_FRAME)
                            overrun = 1'b1;
                        else
                        begin
                            if (fill == 0)
                                cmd = b;
                            else
                            begin
                                r.data_valid = 1'b1;
                                r.data_byte  = b;
                            end
                            fill = fill + 1'b1;
                        end
                    end
                end
            end
            KIND_POLL:
            begin
                // Elapsed time wraps modulo 2^32; a zero timeout always fires
                if ((fr_open || esc_pend)
                    && (w.now_ms - last_ms) >= {{(TIME_W-TIMEOUT_W){1'b0}}, idle_ms})
                begin
                    drop_frame();
                    last_ms   = w.now_ms;
                    r.aborted = 1'b1;
                end
            end
            KIND_RESET:
            begin
                r.aborted = fr_open || esc_pend;
                drop_frame();
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Monitors: predict on input acceptance, check on result acceptance
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && rx_valid && !rx_stall)
            due_words.push_back(deframe_step(rx_word));
    end

    task automatic report_mismatch(string what, kfd_out_t want, kfd_out_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected cons=%0b dv=%0b byte=%02h end=%0b ok=%0b len=%0d ab=%0b",
                     $realtime, what, want.consumed, want.data_valid, want.data_byte,
                     want.frame_end, want.frame_ok, want.frame_length, want.aborted,
                     "\n    actual   cons=%0b dv=%0b byte=%02h end=%0b ok=%0b len=%0d ab=%0b",
                     got.consumed, got.data_valid, got.data_byte,
                     got.frame_end, got.frame_ok, got.frame_length, got.aborted);
    endtask

    always @(posedge clk)
    begin : check_results
        kfd_out_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (due_words.size() == 0)
                report_mismatch("unexpected result word", '0, res_word);
            else
            begin
                want = due_words.pop_front();
                if (res_word.consumed     !== want.consumed
                    || res_word.data_valid   !== want.data_valid
                    || res_word.data_byte    !== want.data_byte
                    || res_word.frame_end    !== want.frame_end
                    || res_word.frame_ok     !== want.frame_ok
                    || res_word.frame_length !== want.frame_length
                    || res_word.aborted      !== want.aborted)
                    report_mismatch("result mismatch", want, res_word);
            end
        end
    end

    // Random back-pressure on the result channel, about 13 percent of the time
    always @(posedge clk)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
            res_stall <= !quiet && ($urandom_range(99) < 13);
    end

    // End the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_valid && !rx_stall) || (res_valid && !res_stall))
                idle_count = 0;
            else
            begin
                idle_count++;
                if (idle_count >= WATCHDOG_LIMIT)
                begin
                    $display("kiss_frame_deframer regression: fail");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. Each is entered and left on a rising edge.
    // ------------------------------------------------------------------------

    // Present one word and hold it until the block takes it. Valid stays high
    // on return so back-to-back words need no dead cycle.
    task automatic push_word(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] b,
                             logic [TIME_W-1:0] t);
        kfd_in_t w;
        w.kind       = kind;
        w.byte_value = b;
        w.now_ms     = t;
        if (!quiet)
        begin
            while ($urandom_range(99) < 13)
            begin
                rx_valid <= 1'b0;
                @(posedge clk);
            end
        end
        rx_valid <= 1'b1;
        rx_word  <= w;
        do
            @(posedge clk);
        while (rx_stall);
        items_sent++;
    endtask

    // Write one register while the block is idle and mirror it in the model
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DELIVER_ENABLE)
            dlv_en = data[0];
        else if (idx == CFG_IDLE_TIMEOUT)
            idle_ms = data;
        @(posedge clk);
    endtask

    // Drop valid and hold until every owed result word has come back
    task automatic wait_drained();
        rx_valid <= 1'b0;
        while (results_seen < items_sent)
            @(posedge clk);
    endtask

    // Advance time a little and send one raw serial byte
    task automatic send_byte(logic [BYTE_W-1:0] b);
        ms_now       = ms_now + $urandom_range(0, 3);
        last_byte_ms = ms_now;
        push_word(KIND_BYTE, b, ms_now);
    endtask

    // Send one frame byte with KISS escaping applied
    task automatic send_escaped(logic [BYTE_W-1:0] b);
        if (b == FEND_CODE)
        begin
            send_byte(FESC_CODE);
            send_byte(TFEND_CODE);
        end
        else if (b == FESC_CODE)
        begin
            send_byte(FESC_CODE);
            send_byte(TFESC_CODE);
        end
        else
            send_byte(b);
    endtask

    // Random byte, biased toward the KISS special codes
    function automatic logic [BYTE_W-1:0] pick_byte();
        logic [BYTE_W-1:0] specials[4];
        specials = '{FEND_CODE, FESC_CODE, TFEND_CODE, TFESC_CODE};
        if ($urandom_range(3) == 0)
            return specials[$urandom_range(3)];
        return BYTE_W'($urandom());
    endfunction

    // Poll tick placed around the timeout boundary, relative to the last byte
    task automatic send_poll();
        logic [TIME_W-1:0] delta;
        logic [TIME_W-1:0] t;
        case ($urandom_range(5))
            0:       delta = '0;
            1:       delta = gen_timeout - 1;
            2:       delta = gen_timeout;
            3:       delta = $urandom_range(0, 2 * gen_timeout + 1);
            4:       delta = $urandom_range(0, gen_timeout / 2);
            default: delta = $urandom();
        endcase
        t      = last_byte_ms + delta;
        ms_now = t;
        if (delta >= gen_timeout)
            last_byte_ms = t;
        push_word(KIND_POLL, BYTE_W'($urandom()), t);
    endtask

    // One frame with random content; a few are broken off or disturbed
    task automatic send_frame_random();
        int                nbody;
        logic [BYTE_W-1:0] frame_cmd;
        nbody     = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        frame_cmd = ($urandom_range(3) != 0) ? CMD_DATA_PORT0 : BYTE_W'($urandom());
        send_byte(FEND_CODE);
        // Leave some frames empty so the closing FEND finds nothing stored
        if ($urandom_range(11) == 0)
            nbody = -1;
        else
            send_escaped(frame_cmd);
        for (int i = 0; i < nbody; i++)
        begin
            case ($urandom_range(39))
                0: send_poll();
                1:
                begin
                    push_word(KIND_RESET, BYTE_W'($urandom()), $urandom());
                    return;
                end
                2:
                begin
                    // Escape followed by any byte, unknown escapes included
                    send_byte(FESC_CODE);
                    send_byte(BYTE_W'($urandom()));
                end
                3: return;
                default: send_escaped(pick_byte());
            endcase
        end
        send_byte(FEND_CODE);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked words: escapes, verdicts, timeout boundary, reset requests
    task automatic test_directed();
        write_reg(CFG_DELIVER_ENABLE, {{(CFG_DATA_W-1){1'b0}}, 1'b1});
        quiet = 1'b0;
        // Byte and poll with no frame open: plain text, nothing to abort
        push_word(KIND_BYTE, 8'h41, 32'd0);
        push_word(KIND_POLL, 8'h00, 32'd5000);
        // Good port 0 frame with both escapes and an unknown escape
        push_word(KIND_BYTE, FEND_CODE, 32'd1);
        push_word(KIND_BYTE, CMD_DATA_PORT0, 32'd2);
        push_word(KIND_BYTE, 8'h00, 32'd3);
        push_word(KIND_BYTE, 8'hFF, 32'd4);
        push_word(KIND_BYTE, FESC_CODE, 32'd5);
        push_word(KIND_BYTE, TFEND_CODE, 32'd6);
        push_word(KIND_BYTE, FESC_CODE, 32'd7);
        push_word(KIND_BYTE, TFESC_CODE, 32'd8);
        push_word(KIND_BYTE, FESC_CODE, 32'd9);
        push_word(KIND_BYTE, 8'h41, 32'd10);
        push_word(KIND_BYTE, FEND_CODE, 32'd11);
        // Back-to-back FEND closes an empty frame
        push_word(KIND_BYTE, FEND_CODE, 32'd12);
        // Shortest deliverable frame: command plus one body byte
        push_word(KIND_BYTE, CMD_DATA_PORT0, 32'd13);
        push_word(KIND_BYTE, 8'h55, 32'd14);
        push_word(KIND_BYTE, FEND_CODE, 32'd15);
        // Frame for another port is discarded
        push_word(KIND_BYTE, 8'h10, 32'd16);
        push_word(KIND_BYTE, 8'h22, 32'd17);
        push_word(KIND_BYTE, FEND_CODE, 32'hFFFF_FE00);
        // Polls across the timeout boundary, with the clock wrapping
        push_word(KIND_POLL, 8'hA5, 32'hFFFF_FE00 + 32'd999);
        push_word(KIND_POLL, 8'h5A, 32'hFFFF_FE00 + 32'd1000);
        // Reset request with nothing open, then with an escape pending
        push_word(KIND_RESET, 8'h00, 32'd0);
        push_word(KIND_BYTE, FEND_CODE, 32'd20);
        push_word(KIND_BYTE, FESC_CODE, 32'd21);
        push_word(KIND_RESET, 8'hFF, 32'hFFFF_FFFF);
        // Undefined kind changes nothing
        push_word(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF);
    endtask

    // Exactly full frame, then one that overruns, with no idling at all
    task automatic test_full_and_overrun();
        wait_drained();
        write_reg(CFG_DELIVER_ENABLE, {{(CFG_DATA_W-1){1'b0}}, 1'b1});
        quiet = 1'b1;
        send_byte(FEND_CODE);
        send_escaped(CMD_DATA_PORT0);
        repeat (MAX_FRAME - 1)
            send_escaped(pick_byte());
        send_byte(FEND_CODE);
        send_escaped(CMD_DATA_PORT0);
        repeat (MAX_FRAME + 1)
            send_escaped(pick_byte());
        send_byte(FEND_CODE);
    endtask

    // Random traffic under one register setting
    task automatic test_random_phase(bit en, logic [TIMEOUT_W-1:0] tmo, int n_items);
        int stop_at;
        int pick;
        wait_drained();
        write_reg(CFG_DELIVER_ENABLE, {{(CFG_DATA_W-1){1'b0}}, en});
        write_reg(CFG_IDLE_TIMEOUT, tmo);
        quiet        = 1'b0;
        gen_timeout  = {{(TIME_W-TIMEOUT_W){1'b0}}, tmo};
        ms_now       = $urandom();
        last_byte_ms = ms_now;
        stop_at      = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 62)
                send_frame_random();
            else if (pick < 72)
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(BYTE_W'($urandom()));
            end
            else if (pick < 84)
                send_poll();
            else if (pick < 91)
                push_word(KIND_RESET, BYTE_W'($urandom()), $urandom());
            else if (pick < 95)
                push_word(KIND_UNUSED, BYTE_W'($urandom()), $urandom());
            else
                send_byte(pick_byte());
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_and_overrun();
        test_random_phase(1'b1, IDLE_TIMEOUT_RESET, PHASE_ITEMS);
        test_random_phase(1'b1, 16'd1, PHASE_ITEMS);
        test_random_phase(1'b0, 16'hFFFF, PHASE_ITEMS);
        test_random_phase(1'b1, 16'd0, PHASE_ITEMS);
        test_random_phase(1'($urandom_range(1)), TIMEOUT_W'($urandom_range(2, 65534)),
                          PHASE_ITEMS);

        // Drain, then give any stray word time to show up
        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && due_words.size() == 0)
            $display("kiss_frame_deframer regression: pass");
        else
            $display("kiss_frame_deframer regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/kfd_pkg.sv
src/kfd_core.sv
src/kfd_out_fifo.sv
src/kiss_frame_deframer.sv
test/kiss_frame_deframer_test.sv
